// ===== sv/cc_pkg.sv =====
// Shared types and constants for the calendar clock.
// Holds the transaction payloads, the time-of-day record and the calendar limits.
// Depends on nothing; every other file of the block but cc_cfg_if imports it.
`default_nettype none

package cc_pkg;

  // Item function codes.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // Field widths.
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MOD_W   = 11;
  localparam int unsigned SOD_W   = 17;
  localparam int unsigned DATE_W  = 28;

  // Calendar limits and scales.
  localparam int unsigned SEC_PER_MIN      = 60;
  localparam int unsigned MIN_PER_HOUR     = 60;
  localparam int unsigned HOUR_PER_DAY     = 24;
  localparam int unsigned MAX_SECOND       = 59;
  localparam int unsigned MAX_MINUTE       = 59;
  localparam int unsigned MAX_DAY          = 31;
  localparam int unsigned MAX_MONTH        = 12;
  localparam int unsigned MAX_WEEKDAY      = 7;
  localparam int unsigned HALF_MINUTE      = 30;
  localparam int unsigned DATE_YEAR_SCALE  = 10000;
  localparam int unsigned DATE_MONTH_SCALE = 100;

  // Reset time of day.
  localparam int unsigned RESET_WEEKDAY = 1;
  localparam int unsigned RESET_HOUR    = 8;

  // Input transaction: a tick or a set-time command.
  typedef struct packed {
    logic               func;
    logic [YEAR_W-1:0]  set_year;
    logic [3:0]         set_month;
    logic [5:0]         set_day;
    logic [3:0]         set_weekday;
    logic [4:0]         set_hour;
    logic [5:0]         set_minute;
    logic [5:0]         set_second;
  } req_t;

  // Current calendar and time of day.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } clock_state_t;

  // Handover from the time core to the formatter.
  typedef struct packed {
    clock_state_t tm;
    logic         redisplay;
    logic         check_reserve;
  } stage_t;

  // Result transaction.
  typedef struct packed {
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;
    logic [WDAY_W-1:0]  weekday_out;
    logic [HOUR_W-1:0]  hour_out;
    logic [MIN_W-1:0]   minute_out;
    logic [SEC_W-1:0]   second_out;
    logic [MOD_W-1:0]   minute_of_day;
    logic [SOD_W-1:0]   second_of_day;
    logic [DATE_W-1:0]  date_code;
    logic               redisplay;
    logic               check_reserve;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/cc_req_if.sv =====
// Input channel of the calendar clock: valid/ready with a tick or set payload.
// Depends on cc_pkg for the payload type.
`default_nettype none

interface cc_req_if;
  import cc_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/cc_rsp_if.sv =====
// Result channel of the calendar clock: valid/ready with the formatted time.
// Depends on cc_pkg for the payload type.
`default_nettype none

interface cc_rsp_if;
  import cc_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/cc_cfg_if.sv =====
// Configuration write channel of the calendar clock: carries the hold bit.
// Depends on nothing.
`default_nettype none

interface cc_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/cc_time_core.sv =====
// Time-keeping core: holds the clock state, one tick or set per unstalled cycle.
// Depends on cc_pkg, cc_req_if and cc_cfg_if.
`default_nettype none

module cc_time_core (
  input  logic            clk,
  input  logic            rst,
  cc_cfg_if.sink          cfg,
  cc_req_if.sink          req,
  output logic            stg_valid,
  output cc_pkg::stage_t  stg,
  input  logic            stg_ready
);
  import cc_pkg::*;

  logic         hold_clock;
  clock_state_t cur;
  clock_state_t cur_next;
  clock_state_t tick_state;
  logic         redisplay;
  logic         redisplay_next;
  logic         check_reserve;
  logic         check_next;
  logic         accept;
  logic         tick_roll;
  logic         tick_check;

  // Leap-year detection: divisibility by 100 via a reciprocal multiply on year/4.
  logic [11:0] year_q4;
  logic [24:0] recip_prod;
  logic [7:0]  cent_q;
  logic [11:0] cent_rem;
  logic        div4;
  logic        div100;
  logic        div400;
  logic        leap;
  logic [DAY_W-1:0] month_days;

  // Carry chain signals.
  logic [SEC_W:0]   sec_inc;
  logic [MIN_W:0]   min_inc;
  logic [HOUR_W:0]  hour_inc;
  logic [WDAY_W:0]  wday_inc;
  logic [DAY_W:0]   day_inc;
  logic [MONTH_W:0] month_inc;
  logic carry_sec;
  logic carry_min;
  logic carry_hour;
  logic carry_month;
  logic carry_year;

  // The configuration register is always writable.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_clock <= 1'b0;
    end else if (cfg.valid) begin
      hold_clock <= cfg.data;
    end
  end

  // A new transaction enters whenever the handover stage is free or draining.
  assign req.ready = !stg_valid || stg_ready;
  assign accept    = req.valid && req.ready;

  // Gregorian leap rule; year zero counts as a leap year.
  always_comb begin
    div4       = (cur.year[1:0] == 2'b00);
    year_q4    = cur.year[YEAR_W-1:2];
    recip_prod = 25'(year_q4) * 25'd5243;
    cent_q     = recip_prod[24:17];
    cent_rem   = year_q4 - 12'(cent_q) * 12'd25;
    div100     = div4 && (cent_rem == 12'd0);
    div400     = div100 && (cent_q[1:0] == 2'b00);
    leap       = (div4 && !div100) || div400;
  end

  // Length of the current month; month zero counts as thirty days.
  always_comb begin
    case (cur.month)
      4'd2:    month_days = leap ? 5'd29 : 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:
               month_days = 5'd31;
      default: month_days = 5'd30;
    endcase
  end

  // One-second advance, carrying into minute, hour, weekday, day, month and year.
  always_comb begin
    tick_state  = cur;
    sec_inc     = {1'b0, cur.second} + 7'd1;
    carry_sec   = (sec_inc >= 7'(SEC_PER_MIN));
    min_inc     = {1'b0, cur.minute} + {{MIN_W{1'b0}}, carry_sec};
    carry_min   = (min_inc >= 7'(MIN_PER_HOUR));
    hour_inc    = {1'b0, cur.hour} + {{HOUR_W{1'b0}}, carry_min};
    carry_hour  = (hour_inc >= 6'(HOUR_PER_DAY));
    wday_inc    = {1'b0, cur.weekday} + 4'd1;
    day_inc     = {1'b0, cur.day} + 6'd1;
    carry_month = (day_inc > {1'b0, month_days});
    month_inc   = {1'b0, cur.month} + 5'd1;
    carry_year  = (month_inc > 5'(MAX_MONTH));

    tick_state.second = carry_sec ? '0 : sec_inc[SEC_W-1:0];
    tick_state.minute = carry_min ? '0 : min_inc[MIN_W-1:0];
    tick_state.hour   = carry_hour ? '0 : hour_inc[HOUR_W-1:0];
    if (carry_hour) begin
      tick_state.weekday = (wday_inc > 4'(MAX_WEEKDAY)) ? 3'd1 : wday_inc[WDAY_W-1:0];
      tick_state.day     = carry_month ? 5'd1 : day_inc[DAY_W-1:0];
      if (carry_month) begin
        tick_state.month = carry_year ? 4'd1 : month_inc[MONTH_W-1:0];
        if (carry_year) begin
          tick_state.year = cur.year + 14'd1;
        end
      end
    end

    // Any rollover starts with the seconds wrapping.
    tick_roll  = carry_sec;
    tick_check = (tick_state.second == 6'd0) || (tick_state.second == 6'(HALF_MINUTE));
  end

  // Choose between a set, an unheld tick and a held tick.
  always_comb begin
    cur_next       = cur;
    redisplay_next = 1'b0;
    check_next     = 1'b0;
    if (req.data.func == FUNC_SET) begin
      cur_next.year    = req.data.set_year;
      cur_next.month   = (req.data.set_month > 4'(MAX_MONTH)) ?
                         4'(MAX_MONTH) : req.data.set_month;
      cur_next.day     = (req.data.set_day > 6'(MAX_DAY)) ?
                         5'(MAX_DAY) : req.data.set_day[DAY_W-1:0];
      cur_next.weekday = (req.data.set_weekday > 4'(MAX_WEEKDAY)) ?
                         3'(MAX_WEEKDAY) : req.data.set_weekday[WDAY_W-1:0];
      cur_next.hour    = (req.data.set_hour >= 5'(HOUR_PER_DAY)) ?
                         req.data.set_hour - 5'(HOUR_PER_DAY) : req.data.set_hour;
      cur_next.minute  = (req.data.set_minute > 6'(MAX_MINUTE)) ?
                         6'(MAX_MINUTE) : req.data.set_minute;
      cur_next.second  = (req.data.set_second > 6'(MAX_SECOND)) ?
                         6'(MAX_SECOND) : req.data.set_second;
      redisplay_next   = 1'b1;
    end else if (!hold_clock) begin
      cur_next       = tick_state;
      redisplay_next = tick_roll;
      check_next     = tick_check;
    end
  end

  // Clock state, flags and handover valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.year    <= '0;
      cur.month   <= '0;
      cur.day     <= '0;
      cur.weekday <= WDAY_W'(RESET_WEEKDAY);
      cur.hour    <= HOUR_W'(RESET_HOUR);
      cur.minute  <= '0;
      cur.second  <= '0;
      stg_valid   <= 1'b0;
    end else begin
      if (accept) begin
        cur           <= cur_next;
        redisplay     <= redisplay_next;
        check_reserve <= check_next;
      end
      if (req.ready) begin
        stg_valid <= accept;
      end
    end
  end

  // The state register doubles as the handover payload: it only moves on entry.
  assign stg.tm            = cur;
  assign stg.redisplay     = redisplay;
  assign stg.check_reserve = check_reserve;

  // A held tick changes nothing and flags nothing.
  a_hold_freezes: assert property (@(posedge clk) disable iff (rst)
    accept && (req.data.func == FUNC_TICK) && hold_clock |=>
      $stable(cur) && !redisplay && !check_reserve)
    else $error("held tick altered the clock");

  // A stalled handover keeps its transaction and the state under it.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stg_valid && !stg_ready |=> stg_valid && $stable(cur))
    else $error("clock state moved under a stalled transaction");

  // The time of day never leaves its range.
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (cur.second <= 6'(MAX_SECOND)) && (cur.minute <= 6'(MAX_MINUTE)) &&
    (cur.hour < 5'(HOUR_PER_DAY)))
    else $error("time of day out of range");

  // A redisplay after a tick means the seconds have just wrapped.
  a_roll_at_zero: assert property (@(posedge clk) disable iff (rst)
    accept && (req.data.func == FUNC_TICK) |=> !redisplay || (cur.second == 6'd0))
    else $error("redisplay on a tick without a minute rollover");

endmodule

`default_nettype wire

// ===== sv/cc_format.sv =====
// Result formatter: derives the day counts and date code and holds the result register.
// Depends on cc_pkg and cc_rsp_if.
`default_nettype none

module cc_format (
  input  logic            clk,
  input  logic            rst,
  input  logic            stg_valid,
  input  cc_pkg::stage_t  stg,
  output logic            stg_ready,
  cc_rsp_if.source        rsp
);
  import cc_pkg::*;

  logic [MOD_W-1:0]  minute_of_day;
  logic [SOD_W-1:0]  second_of_day;
  logic [DATE_W-1:0] date_code;

  // The result register takes a new transaction when empty or being drained.
  assign stg_ready = !rsp.valid || rsp.ready;

  // Derived counts from the handed-over time.
  always_comb begin
    minute_of_day = MOD_W'(stg.tm.hour) * MOD_W'(MIN_PER_HOUR) + MOD_W'(stg.tm.minute);
    second_of_day = SOD_W'(minute_of_day) * SOD_W'(SEC_PER_MIN) + SOD_W'(stg.tm.second);
    date_code     = DATE_W'(stg.tm.year) * DATE_W'(DATE_YEAR_SCALE) +
                    DATE_W'(stg.tm.month) * DATE_W'(DATE_MONTH_SCALE) +
                    DATE_W'(stg.tm.day);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (stg_ready) begin
      rsp.valid <= stg_valid;
    end
    if (stg_ready && stg_valid) begin
      rsp.data.year_out      <= stg.tm.year;
      rsp.data.month_out     <= stg.tm.month;
      rsp.data.day_out       <= stg.tm.day;
      rsp.data.weekday_out   <= stg.tm.weekday;
      rsp.data.hour_out      <= stg.tm.hour;
      rsp.data.minute_out    <= stg.tm.minute;
      rsp.data.second_out    <= stg.tm.second;
      rsp.data.minute_of_day <= minute_of_day;
      rsp.data.second_of_day <= second_of_day;
      rsp.data.date_code     <= date_code;
      rsp.data.redisplay     <= stg.redisplay;
      rsp.data.check_reserve <= stg.check_reserve;
    end
  end

endmodule

`default_nettype wire

// ===== sv/calendar_clock.sv =====
// Calendar clock top level: one time core feeding one result formatter.
// Depends on cc_pkg, the three channel interfaces, cc_time_core and cc_format.
//
// Use: each transaction on req is either a one-second tick (func = 0) or a
// set-time command (func = 1) with its set fields; every transaction yields
// exactly one transaction on rsp carrying the time after it, the minute and
// second of the day, the packed date code and the redisplay and reserve flags.
// The cfg channel writes the hold bit, which freezes ticks; it is always ready
// and the user must write it only while no transaction is in flight; the
// block itself does not enforce this. The result passes through the
// clock-state register and then the result register before it shows on rsp.
// One transaction is accepted per cycle while results are taken: the state
// update is a single carry chain after the clock-state register, and the
// derived counts and the year-times-ten-thousand product go from that
// register into the result register.
// Reset sets the clock to year 0, month 0, day 0, weekday 1, 08:00:00, clears
// the hold bit and empties both stages. When the receiver stalls, the result
// register and the handover stage each hold one transaction and req.ready
// falls until the result is taken.
`default_nettype none

module calendar_clock (
  input  logic   clk,
  input  logic   rst,
  cc_cfg_if.sink cfg,
  cc_req_if.sink req,
  cc_rsp_if.source rsp
);
  import cc_pkg::*;

  logic   stg_valid;
  logic   stg_ready;
  stage_t stg;

  // State update and hold register.
  cc_time_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .stg_valid (stg_valid),
    .stg       (stg),
    .stg_ready (stg_ready)
  );

  // Derived fields and result register.
  cc_format u_format (
    .clk       (clk),
    .rst       (rst),
    .stg_valid (stg_valid),
    .stg       (stg),
    .stg_ready (stg_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== tb/sv/calendar_board_pkg.sv =====
// Scoreboard for the calendar clock testbench: predicts each result and checks it.
// Depends on cc_pkg for the request and result transaction types and the calendar limits.
`timescale 1ns / 100ps

package calendar_board_pkg;
  import cc_pkg::*;

  class calendar_board;
    // Predicted clock state, kept in plain integers so carries cannot wrap early.
    int year;
    int month;
    int day;
    int weekday;
    int hour;
    int minute;
    int sec;
    bit held;
    int failures;
    rsp_t expected_times[$];

    function new();
      year = 0;
      month = 0;
      day = 0;
      weekday = RESET_WEEKDAY;
      hour = RESET_HOUR;
      minute = 0;
      sec = 0;
      held = 1'b0;
      failures = 0;
    endfunction

    // Gregorian month length; month zero and unknown months count as 30 days.
    function int days_in_month();
      bit leap;
      leap = ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
      case (month)
        2: return leap ? 29 : 28;
        1, 3, 5, 7, 8, 10, 12: return 31;
        default: return 30;
      endcase
    endfunction

    // Applies one accepted request transaction and queues the result it must give.
    function void note_request(req_t r);
      rsp_t e;
      bit redraw;
      bit reserve;
      int len;
      redraw = 1'b0;
      reserve = 1'b0;
      if (r.func == FUNC_SET) begin
        year = int'(r.set_year);
        month = int'(r.set_month);
        if (month > MAX_MONTH) month = MAX_MONTH;
        day = int'(r.set_day);
        if (day > MAX_DAY) day = MAX_DAY;
        weekday = int'(r.set_weekday);
        if (weekday > MAX_WEEKDAY) weekday = MAX_WEEKDAY;
        hour = int'(r.set_hour) % HOUR_PER_DAY;
        minute = int'(r.set_minute);
        if (minute > MAX_MINUTE) minute = MAX_MINUTE;
        sec = int'(r.set_second);
        if (sec > MAX_SECOND) sec = MAX_SECOND;
        redraw = 1'b1;
      end else if (!held) begin
        // Carry cascade from seconds up to the year.
        sec = sec + 1;
        if (sec >= SEC_PER_MIN) begin
          sec = 0;
          minute = minute + 1;
          redraw = 1'b1;
        end
        if (minute >= MIN_PER_HOUR) begin
          minute = 0;
          hour = hour + 1;
          redraw = 1'b1;
        end
        if (hour >= HOUR_PER_DAY) begin
          hour = 0;
          redraw = 1'b1;
          len = days_in_month();
          weekday = weekday + 1;
          if (weekday > MAX_WEEKDAY) weekday = 1;
          day = day + 1;
          if (day > len) begin
            day = 1;
            month = month + 1;
            if (month > MAX_MONTH) begin
              month = 1;
              year = (year + 1) % (1 << YEAR_W);
            end
          end
        end
        reserve = (sec == 0 || sec == HALF_MINUTE);
      end

      e.year_out = YEAR_W'(year);
      e.month_out = MONTH_W'(month);
      e.day_out = DAY_W'(day);
      e.weekday_out = WDAY_W'(weekday);
      e.hour_out = HOUR_W'(hour);
      e.minute_out = MIN_W'(minute);
      e.second_out = SEC_W'(sec);
      e.minute_of_day = MOD_W'(hour * MIN_PER_HOUR + minute);
      e.second_of_day = SOD_W'(hour * MIN_PER_HOUR * SEC_PER_MIN + minute * SEC_PER_MIN + sec);
      e.date_code = DATE_W'(longint'(year) * DATE_YEAR_SCALE + month * DATE_MONTH_SCALE + day);
      e.redisplay = redraw;
      e.check_reserve = reserve;
      expected_times.push_back(e);
    endfunction

    function void field_check(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
        failures++;
      end
    endfunction

    // Compares one accepted result transaction with the oldest prediction.
    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_times.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %p", $time, got);
        failures++;
        return;
      end
      e = expected_times.pop_front();
      field_check("year_out", e.year_out, got.year_out);
      field_check("month_out", e.month_out, got.month_out);
      field_check("day_out", e.day_out, got.day_out);
      field_check("weekday_out", e.weekday_out, got.weekday_out);
      field_check("hour_out", e.hour_out, got.hour_out);
      field_check("minute_out", e.minute_out, got.minute_out);
      field_check("second_out", e.second_out, got.second_out);
      field_check("minute_of_day", e.minute_of_day, got.minute_of_day);
      field_check("second_of_day", e.second_of_day, got.second_of_day);
      field_check("date_code", e.date_code, got.date_code);
      field_check("redisplay", e.redisplay, got.redisplay);
      field_check("check_reserve", e.check_reserve, got.check_reserve);
    endfunction
  endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Top-level testbench of the calendar clock: drives ticks, set-time commands and hold writes.
// Depends on cc_pkg, the three channel interfaces, calendar_board_pkg and calendar_clock.
`timescale 1ns / 100ps

module testbench;
  import cc_pkg::*;
  import calendar_board_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cc_cfg_if hold_wr ();
  cc_req_if time_req ();
  cc_rsp_if time_rsp ();

  calendar_board board;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_count = 0;

  calendar_clock dut (
    .clk(clk),
    .rst(rst),
    .cfg(hold_wr),
    .req(time_req),
    .rsp(time_rsp)
  );

  always #2 clk = ~clk;

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // Result receiver: checks each transaction and stalls on a changing pattern.
  always @(posedge clk) begin
    if (!rst && time_rsp.valid && time_rsp.ready) board.check_result(time_rsp.data);
    stall_count = stall_count + 1;
    if (stall_count % 50 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: time_rsp.ready <= 1'b1;
      1: time_rsp.ready <= ($urandom_range(0, 99) >= 30);
      2: time_rsp.ready <= (stall_count % 3 != 0);
      default: time_rsp.ready <= (stall_count % 16 >= 10);
    endcase
  end

  // Offers one request transaction, with sender bursts and gaps in between.
  task automatic push_item(req_t item);
    if (burst_left == 0) begin
      time_req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    time_req.valid <= 1'b1;
    time_req.data <= item;
    do @(posedge clk); while (!time_req.ready);
    board.note_request(item);
    burst_left--;
  endtask

  // A tick carries random set fields, which the block must ignore.
  task automatic tick();
    logic [63:0] noise;
    req_t item;
    noise = {$urandom, $urandom};
    item = noise[$bits(req_t)-1:0];
    item.func = FUNC_TICK;
    push_item(item);
  endtask

  task automatic set_time(int y, int mo, int d, int w, int h, int mi, int s);
    req_t item;
    item.func = FUNC_SET;
    item.set_year = YEAR_W'(y);
    item.set_month = 4'(mo);
    item.set_day = 6'(d);
    item.set_weekday = 4'(w);
    item.set_hour = 5'(h);
    item.set_minute = 6'(mi);
    item.set_second = 6'(s);
    push_item(item);
  endtask

  // Mostly ticks; some sets land just short of a rollover, others are pure noise.
  task automatic random_item();
    logic [63:0] noise;
    req_t item;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      tick();
    end else if (pick < 85) begin
      case ($urandom_range(0, 4))
        0: item.set_year = '0;
        1: item.set_year = '1;
        2: item.set_year = YEAR_W'($urandom_range(1896, 2104));
        default: item.set_year = YEAR_W'($urandom);
      endcase
      item.func = FUNC_SET;
      item.set_month = 4'($urandom_range(0, 12));
      item.set_day = ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom_range(27, 31));
      item.set_weekday = 4'($urandom_range(0, 7));
      item.set_hour = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd23;
      item.set_minute = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd59;
      item.set_second = 6'($urandom_range(50, 59));
      push_item(item);
    end else begin
      noise = {$urandom, $urandom};
      item = noise[$bits(req_t)-1:0];
      item.func = FUNC_SET;
      push_item(item);
    end
  endtask

  // Stops the sender until every predicted result has been taken.
  task automatic drain();
    time_req.valid <= 1'b0;
    burst_left = 0;
    while (board.expected_times.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_hold(bit v);
    hold_wr.valid <= 1'b1;
    hold_wr.data <= v;
    do @(posedge clk); while (!hold_wr.ready);
    board.held = v;
    hold_wr.valid <= 1'b0;
  endtask

  initial begin
    bit phase_hold[5];
    int phase_len[5];
    phase_hold = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_len = '{180, 60, 170, 60, 180};
    board = new();
    hold_wr.valid = 1'b0;
    hold_wr.data = 1'b0;
    time_req.valid = 1'b0;
    time_req.data = '0;
    time_rsp.ready = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_hold(1'b0);

    // Directed part: clamps, carries and the calendar corner cases.
    tick();
    set_time(16383, 15, 63, 15, 31, 63, 63);
    tick();
    // December rollover with year overflow and weekday wrap.
    set_time(16383, 12, 31, 7, 23, 59, 59);
    tick();
    // All fields zero, hour 24 reduced to midnight.
    set_time(0, 0, 0, 0, 24, 0, 0);
    tick();
    // Month zero lasts 30 days; weekday zero moves to 1.
    set_time(2001, 0, 30, 0, 23, 59, 59);
    tick();
    // Day zero simply advances to the first.
    set_time(2001, 5, 0, 3, 23, 59, 59);
    tick();
    // Day 31 in a 30-day month rolls to the next month.
    set_time(2001, 4, 31, 2, 23, 59, 59);
    tick();
    // Leap years: divisible by 400, century, and year zero.
    set_time(2000, 2, 28, 1, 23, 59, 59);
    tick();
    set_time(1900, 2, 28, 5, 23, 59, 59);
    tick();
    set_time(0, 2, 28, 6, 23, 59, 59);
    tick();
    // Half-minute raises the reserve check.
    set_time(2023, 6, 15, 4, 10, 20, 29);
    tick();

    // Random phases, alternating the hold bit while the block is idle.
    foreach (phase_len[p]) begin
      drain();
      write_hold(phase_hold[p]);
      repeat (phase_len[p]) random_item();
    end

    drain();
    repeat (4) @(posedge clk);
    if (board.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cc_pkg.sv
sv/cc_req_if.sv
sv/cc_rsp_if.sv
sv/cc_cfg_if.sv
sv/cc_time_core.sv
sv/cc_format.sv
sv/calendar_clock.sv
tb/sv/calendar_board_pkg.sv
tb/sv/testbench.sv
